>>> design/spf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg: shared constants and types for the SSH packet framer
// Sizes, limits, register indexes, result codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package spf_pkg;

	localparam int unsigned MAX_PAYLOAD = 32768;
	localparam int unsigned MIN_BLOCK   = 8;
	localparam int unsigned MIN_PADDING = 4;
	localparam int unsigned MAX_BLOCK   = 32;

	// 4-byte packet length plus 1-byte padding length
	localparam int unsigned HDR_BYTES = 5;

	localparam int unsigned LEN_W      = 16;
	localparam int unsigned BLK_W      = 6;
	localparam int unsigned CAP_W      = 16;
	localparam int unsigned PAD_W      = 6;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned DIV_CNT_W  = $clog2(LEN_W);
	localparam int unsigned HDR_CNT_W  = $clog2(HDR_BYTES);
	localparam int unsigned PLEN_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 1'd1;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DATA  = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_TOO_LARGE = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_CAP_SMALL = 2'd2;

	typedef logic [2:0] out_sel_t;

	localparam out_sel_t SEL_ERR_LARGE = 3'd0;
	localparam out_sel_t SEL_ERR_CAP   = 3'd1;
	localparam out_sel_t SEL_HDR       = 3'd2;
	localparam out_sel_t SEL_DATA      = 3'd3;
	localparam out_sel_t SEL_PAD       = 3'd4;

	typedef struct packed {
		logic     load;
		logic     div_step;
		logic     pad_init;
		logic     pad_add;
		logic     emit;
		out_sel_t sel;
	} spf_cmd_t;

	typedef struct packed {
		logic out_free;
		logic len_big;
		logic div_last;
		logic pad_small;
		logic cap_err;
		logic hdr_last;
		logic len_zero;
		logic pad_zero;
		logic data_last;
		logic pad_last;
	} spf_sts_t;

endpackage

>>> design/spf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_in_if: input channel of the SSH packet framer
// Start items and payload byte items, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spf_in_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [spf_pkg::LEN_W-1:0]    payload_length;
	logic [spf_pkg::BYTE_W-1:0]   data_byte;

	modport source (output valid, output action, output payload_length,
		output data_byte, input ready);
	modport sink (input valid, input action, input payload_length,
		input data_byte, output ready);
endinterface

>>> design/spf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_out_if: output channel of the SSH packet framer
// One encoded byte or one error result per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spf_out_if;
	logic                         valid;
	logic                         ready;
	logic [spf_pkg::BYTE_W-1:0]   out_byte;
	logic                         is_last;
	logic [spf_pkg::STAT_W-1:0]   status;

	modport source (output valid, output out_byte, output is_last,
		output status, input ready);
	modport sink (input valid, input out_byte, input is_last,
		input status, output ready);
endinterface

>>> design/ssh_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_packet_framer: byte-serial SSH binary packet framer
// Frames a payload into an unencrypted SSH packet with zero padding.
// ----------------------------------------------------------------------------
// A start word carries the payload length; the framer then works out
// 5 + length modulo the block size in a bit-serial remainder unit, forms
// the padding, adding one block at a time to reach the minimum padding,
// and does the capacity check, before it sends the five header words
// (packet length big-endian, then padding length) at one per cycle.
// Payload byte words are then taken and echoed one per cycle; after the
// last one the zero padding words follow at one per cycle, during which
// no input is taken. A length above the payload limit or a packet too big
// for the output capacity gives a single error word. Output words sit in a
// one-word output register; a stalled output holds the framer.
module ssh_packet_framer (
	input  logic                               clk,
	input  logic                               arst_n,
	spf_in_if.sink                             in_ch,
	spf_out_if.source                          out_ch,
	input  logic                               cfg_we,
	input  logic [spf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	spf_pkg::spf_cmd_t cmd;
	spf_pkg::spf_sts_t sts;

	spf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_action (in_ch.action),
		.in_ready  (in_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	spf_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_len     (in_ch.payload_length),
		.in_byte    (in_ch.data_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_byte   (out_ch.out_byte),
		.out_last   (out_ch.is_last),
		.out_status (out_ch.status)
	);

endmodule

>>> design/spf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_datapath: framer datapath
// Config registers, bit-serial remainder unit, padding and counters, and the
// output word register.
// ----------------------------------------------------------------------------
module spf_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spf_pkg::spf_cmd_t                 cmd,
	output spf_pkg::spf_sts_t                 sts,
	input  logic [spf_pkg::LEN_W-1:0]         in_len,
	input  logic [spf_pkg::BYTE_W-1:0]        in_byte,
	input  logic                              cfg_we,
	input  logic [spf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [spf_pkg::BYTE_W-1:0]        out_byte,
	output logic                              out_last,
	output logic [spf_pkg::STAT_W-1:0]        out_status
);

	logic [spf_pkg::BLK_W-1:0]     block_size_q;
	logic [spf_pkg::CAP_W-1:0]     capacity_q;
	logic [spf_pkg::BLK_W-1:0]     blk;

	logic [spf_pkg::LEN_W-1:0]     len_q;
	logic [spf_pkg::LEN_W-1:0]     dvd_q;
	logic [spf_pkg::BLK_W-1:0]     rem_q;
	logic [spf_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [spf_pkg::PAD_W-1:0]     pad_q;
	logic [spf_pkg::LEN_W-1:0]     bytes_q;
	logic [spf_pkg::HDR_CNT_W-1:0] hdr_q;

	logic                          out_valid_q;
	logic [spf_pkg::BYTE_W-1:0]    out_byte_q;
	logic                          out_last_q;
	logic [spf_pkg::STAT_W-1:0]    out_status_q;

	logic [spf_pkg::BLK_W:0]       trial;
	logic [spf_pkg::BLK_W-1:0]     rem_d;
	logic [spf_pkg::LEN_W:0]       total;
	logic [spf_pkg::PLEN_W-1:0]    plen;
	logic [spf_pkg::BYTE_W-1:0]    hdr_byte;
	logic [spf_pkg::BYTE_W-1:0]    nxt_byte;
	logic                          nxt_last;
	logic [spf_pkg::STAT_W-1:0]    nxt_status;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= spf_pkg::BLK_W'(8);
			capacity_q   <= {spf_pkg::CAP_W{1'b1}};
		end else if (cfg_we) begin
			case (cfg_index)
				spf_pkg::REG_BLOCK_SIZE:      block_size_q <= cfg_data[spf_pkg::BLK_W-1:0];
				spf_pkg::REG_OUTPUT_CAPACITY: capacity_q   <= cfg_data[spf_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (block_size_q < spf_pkg::BLK_W'(spf_pkg::MIN_BLOCK))
			blk = spf_pkg::BLK_W'(spf_pkg::MIN_BLOCK);
		else if (block_size_q > spf_pkg::BLK_W'(spf_pkg::MAX_BLOCK))
			blk = spf_pkg::BLK_W'(spf_pkg::MAX_BLOCK);
		else
			blk = block_size_q;
	end

	// restoring remainder, one dividend bit per cycle, MSB first
	always_comb begin
		trial = {rem_q, dvd_q[spf_pkg::LEN_W-1]};
		if (trial >= {1'b0, blk})
			rem_d = spf_pkg::BLK_W'(trial - {1'b0, blk});
		else
			rem_d = trial[spf_pkg::BLK_W-1:0];
	end

	assign total = (spf_pkg::LEN_W+1)'(len_q) + (spf_pkg::LEN_W+1)'(pad_q)
		+ (spf_pkg::LEN_W+1)'(spf_pkg::HDR_BYTES);
	assign plen  = spf_pkg::PLEN_W'(len_q) + spf_pkg::PLEN_W'(pad_q) + spf_pkg::PLEN_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q     <= in_len;
			bytes_q   <= in_len;
			dvd_q     <= spf_pkg::LEN_W'(in_len + spf_pkg::LEN_W'(spf_pkg::HDR_BYTES));
			rem_q     <= '0;
			div_cnt_q <= '0;
			hdr_q     <= '0;
		end else begin
			if (cmd.div_step) begin
				rem_q     <= rem_d;
				dvd_q     <= {dvd_q[spf_pkg::LEN_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q + spf_pkg::DIV_CNT_W'(1);
			end
			if (cmd.emit && cmd.sel == spf_pkg::SEL_HDR)
				hdr_q <= hdr_q + spf_pkg::HDR_CNT_W'(1);
			if (cmd.emit && cmd.sel == spf_pkg::SEL_DATA)
				bytes_q <= bytes_q - spf_pkg::LEN_W'(1);
		end

		if (cmd.pad_init)
			pad_q <= (rem_q == '0) ? '0 : spf_pkg::PAD_W'(blk - rem_q);
		else if (cmd.pad_add)
			pad_q <= pad_q + spf_pkg::PAD_W'(blk);
		else if (cmd.emit && cmd.sel == spf_pkg::SEL_PAD)
			pad_q <= pad_q - spf_pkg::PAD_W'(1);
	end

	always_comb begin
		sts.out_free  = !out_valid_q || out_ready;
		sts.len_big   = in_len > spf_pkg::LEN_W'(spf_pkg::MAX_PAYLOAD);
		sts.div_last  = div_cnt_q == spf_pkg::DIV_CNT_W'(spf_pkg::LEN_W - 1);
		sts.pad_small = pad_q < spf_pkg::PAD_W'(spf_pkg::MIN_PADDING);
		sts.cap_err   = total > (spf_pkg::LEN_W+1)'(capacity_q);
		sts.hdr_last  = hdr_q == spf_pkg::HDR_CNT_W'(spf_pkg::HDR_BYTES - 1);
		sts.len_zero  = len_q == '0;
		sts.pad_zero  = pad_q == '0;
		sts.data_last = bytes_q == spf_pkg::LEN_W'(1);
		sts.pad_last  = pad_q == spf_pkg::PAD_W'(1);
	end

	always_comb begin
		case (hdr_q)
			spf_pkg::HDR_CNT_W'(0): hdr_byte = plen[31:24];
			spf_pkg::HDR_CNT_W'(1): hdr_byte = plen[23:16];
			spf_pkg::HDR_CNT_W'(2): hdr_byte = plen[15:8];
			spf_pkg::HDR_CNT_W'(3): hdr_byte = plen[7:0];
			default:                hdr_byte = spf_pkg::BYTE_W'(pad_q);
		endcase
	end

	always_comb begin
		nxt_byte   = '0;
		nxt_last   = 1'b0;
		nxt_status = spf_pkg::STATUS_OK;
		case (cmd.sel)
			spf_pkg::SEL_ERR_LARGE: begin
				nxt_last   = 1'b1;
				nxt_status = spf_pkg::STATUS_TOO_LARGE;
			end
			spf_pkg::SEL_ERR_CAP: begin
				nxt_last   = 1'b1;
				nxt_status = spf_pkg::STATUS_CAP_SMALL;
			end
			spf_pkg::SEL_HDR: begin
				nxt_byte = hdr_byte;
				nxt_last = sts.hdr_last && sts.len_zero && sts.pad_zero;
			end
			spf_pkg::SEL_DATA: begin
				nxt_byte = in_byte;
				nxt_last = sts.data_last && sts.pad_zero;
			end
			spf_pkg::SEL_PAD: begin
				nxt_last = sts.pad_last;
			end
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q   <= nxt_byte;
			out_last_q   <= nxt_last;
			out_status_q <= nxt_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

endmodule

>>> design/spf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_ctrl: framer controller
// Sequences the remainder, padding, capacity check, header, payload and
// padding phases of one packet.
// ----------------------------------------------------------------------------
module spf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_action,
	output logic              in_ready,
	input  spf_pkg::spf_sts_t sts,
	output spf_pkg::spf_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_PADI = 3'd2;
	localparam logic [2:0] S_PADF = 3'd3;
	localparam logic [2:0] S_CAP  = 3'd4;
	localparam logic [2:0] S_HDR  = 3'd5;
	localparam logic [2:0] S_DATA = 3'd6;
	localparam logic [2:0] S_PAD  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE || state_q == S_DATA) && sts.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sel = spf_pkg::SEL_PAD;
		case (state_q)
			S_IDLE, S_DATA: begin
				if (accept) begin
					if (in_action == spf_pkg::ACT_START) begin
						// a start abandons any packet in flight
						if (sts.len_big) begin
							cmd.emit = 1'b1;
							cmd.sel  = spf_pkg::SEL_ERR_LARGE;
							state_d  = S_IDLE;
						end else begin
							cmd.load = 1'b1;
							state_d  = S_DIV;
						end
					end else if (state_q == S_DATA) begin
						cmd.emit = 1'b1;
						cmd.sel  = spf_pkg::SEL_DATA;
						if (sts.data_last)
							state_d = sts.pad_zero ? S_IDLE : S_PAD;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = S_PADI;
			end
			S_PADI: begin
				cmd.pad_init = 1'b1;
				state_d      = S_PADF;
			end
			S_PADF: begin
				if (sts.pad_small)
					cmd.pad_add = 1'b1;
				else
					state_d = S_CAP;
			end
			S_CAP: begin
				if (sts.cap_err) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.sel  = spf_pkg::SEL_ERR_CAP;
						state_d  = S_IDLE;
					end
				end else begin
					state_d = S_HDR;
				end
			end
			S_HDR: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = spf_pkg::SEL_HDR;
					if (sts.hdr_last) begin
						if (!sts.len_zero)
							state_d = S_DATA;
						else
							state_d = sts.pad_zero ? S_IDLE : S_PAD;
					end
				end
			end
			S_PAD: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = spf_pkg::SEL_PAD;
					if (sts.pad_last)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

>>> test/ssh_packet_framer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssh_packet_framer_tb: self-checking testbench for the SSH packet framer
// Drives start and payload byte words with random gaps and output stalls.
// A cycle-free predictor works out the header, echoed, padding and error words
// of each accepted input, and a checker compares every output word with it.
// Register settings sweep block size and output capacity.
// ----------------------------------------------------------------------------
module ssh_packet_framer_tb;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned END_CYCLES     = 64;
	localparam int unsigned PHASES         = 10;
	localparam int unsigned PHASE_WORDS    = 25;

	// block size and output capacity for each random phase
	localparam int unsigned PHASE_BLK [PHASES] = '{8, 0, 16, 32, 13, 63, 40, 31, 24, 8};
	localparam int unsigned PHASE_CAP [PHASES] =
		'{65535, 65535, 200, 65535, 48, 65535, 100, 65535, 40, 65535};

	typedef struct packed {
		logic [spf_pkg::BYTE_W-1:0] out_byte;
		logic                       is_last;
		logic [spf_pkg::STAT_W-1:0] status;
	} frame_word_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [spf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [spf_pkg::CFG_DATA_W-1:0] cfg_data;

	spf_in_if  in_ch ();
	spf_out_if out_ch ();

	ssh_packet_framer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state and register copies
	int unsigned blk_cfg  = 8;
	int unsigned cap_cfg  = 65535;
	logic        pk_open  = 1'b0;
	int unsigned pay_left = 0;
	int unsigned pad_left = 0;

	frame_word_t frame_q [$];

	bit          calm        = 1'b0;
	int unsigned fail_count  = 0;
	int unsigned words_in    = 0;
	int unsigned words_out   = 0;
	int unsigned reg_writes  = 0;
	int unsigned directed_in = 0;
	int unsigned quiet       = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void want(input logic [spf_pkg::BYTE_W-1:0] b, input logic l,
			input logic [spf_pkg::STAT_W-1:0] s);
		frame_word_t w;
		w.out_byte = b;
		w.is_last  = l;
		w.status   = s;
		frame_q.push_back(w);
	endfunction

	function automatic void flush_padding();
		while (pad_left != 0) begin
			pad_left--;
			want('0, pad_left == 0, spf_pkg::STATUS_OK);
		end
		pk_open = 1'b0;
	endfunction

	// expected words for one accepted input word
	function automatic void frame_item(input logic act, input logic [spf_pkg::LEN_W-1:0] len,
			input logic [spf_pkg::BYTE_W-1:0] dat);
		int unsigned blk;
		int unsigned rem;
		int unsigned pad;
		int unsigned plen;
		if (act == spf_pkg::ACT_START) begin
			pk_open  = 1'b0;
			pay_left = 0;
			pad_left = 0;
			if (len > spf_pkg::MAX_PAYLOAD) begin
				want('0, 1'b1, spf_pkg::STATUS_TOO_LARGE);
			end else begin
				blk = blk_cfg;
				if (blk < spf_pkg::MIN_BLOCK) blk = spf_pkg::MIN_BLOCK;
				if (blk > spf_pkg::MAX_BLOCK) blk = spf_pkg::MAX_BLOCK;
				rem = (spf_pkg::HDR_BYTES + len) % blk;
				pad = (rem == 0) ? 0 : blk - rem;
				while (pad < spf_pkg::MIN_PADDING) pad += blk;
				if (spf_pkg::HDR_BYTES + len + pad > cap_cfg) begin
					want('0, 1'b1, spf_pkg::STATUS_CAP_SMALL);
				end else begin
					plen = 1 + len + pad;
					want(plen[31:24], 1'b0, spf_pkg::STATUS_OK);
					want(plen[23:16], 1'b0, spf_pkg::STATUS_OK);
					want(plen[15:8], 1'b0, spf_pkg::STATUS_OK);
					want(plen[7:0], 1'b0, spf_pkg::STATUS_OK);
					want(pad[7:0], (len == 0) && (pad == 0), spf_pkg::STATUS_OK);
					pay_left = len;
					pad_left = pad;
					pk_open  = 1'b1;
					if (len == 0) flush_padding();
				end
			end
		end else if (pk_open && pay_left != 0) begin
			pay_left--;
			want(dat, (pay_left == 0) && (pad_left == 0), spf_pkg::STATUS_OK);
			if (pay_left == 0) flush_padding();
		end
	endfunction

	task automatic send_word(input logic act, input logic [spf_pkg::LEN_W-1:0] len,
			input logic [spf_pkg::BYTE_W-1:0] dat);
		int unsigned gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk) in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid          <= 1'b1;
		in_ch.action         <= act;
		in_ch.payload_length <= len;
		in_ch.data_byte      <= dat;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		words_in++;
		frame_item(act, len, dat);
	endtask

	task automatic send_packet(input int unsigned len);
		send_word(spf_pkg::ACT_START, len[spf_pkg::LEN_W-1:0],
			spf_pkg::BYTE_W'($urandom_range(0, 255)));
		repeat (len)
			send_word(spf_pkg::ACT_DATA, spf_pkg::LEN_W'($urandom_range(0, 65535)),
				spf_pkg::BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic drain_results();
		@(negedge clk) in_ch.valid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);
	endtask

	// idle the framer completely before touching a register
	task automatic settle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [spf_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[spf_pkg::CFG_DATA_W-1:0];
		@(negedge clk) cfg_we <= 1'b0;
		if (idx == spf_pkg::REG_BLOCK_SIZE)
			blk_cfg = value[spf_pkg::BLK_W-1:0];
		else
			cap_cfg = value[spf_pkg::CAP_W-1:0];
		reg_writes++;
	endtask

	task automatic test_basic_framing();
		send_word(spf_pkg::ACT_START, '0, 8'hFF);
		send_word(spf_pkg::ACT_START, 16'd3, 8'h00);
		send_word(spf_pkg::ACT_DATA, 16'hFFFF, 8'h00);
		send_word(spf_pkg::ACT_DATA, 16'h0000, 8'hFF);
		send_word(spf_pkg::ACT_DATA, 16'h1234, 8'hA5);
		send_word(spf_pkg::ACT_DATA, 16'd7, 8'hFF);
		settle();
	endtask

	task automatic test_length_errors();
		send_word(spf_pkg::ACT_START, spf_pkg::LEN_W'(spf_pkg::MAX_PAYLOAD + 1), 8'h3C);
		send_word(spf_pkg::ACT_START, 16'hFFFF, 8'hFF);
		send_word(spf_pkg::ACT_START, spf_pkg::LEN_W'(spf_pkg::MAX_PAYLOAD), 8'h00);
		send_word(spf_pkg::ACT_DATA, 16'h0000, 8'h81);
		send_word(spf_pkg::ACT_DATA, 16'hFFFF, 8'h7E);
		// new start abandons the open packet
		send_word(spf_pkg::ACT_START, 16'd1, 8'h00);
		send_word(spf_pkg::ACT_DATA, 16'h0000, 8'h5A);
		settle();
	endtask

	task automatic test_capacity();
		write_reg(spf_pkg::REG_OUTPUT_CAPACITY, 0);
		send_word(spf_pkg::ACT_START, '0, 8'h00);
		settle();
		// 5 + 3 + 8 lands exactly on the capacity; 12 bytes overflows it
		write_reg(spf_pkg::REG_OUTPUT_CAPACITY, 16);
		send_word(spf_pkg::ACT_START, 16'd3, 8'h00);
		send_word(spf_pkg::ACT_DATA, 16'h0000, 8'h01);
		send_word(spf_pkg::ACT_DATA, 16'h0000, 8'h80);
		send_word(spf_pkg::ACT_DATA, 16'h0000, 8'hFE);
		send_word(spf_pkg::ACT_START, 16'd12, 8'h00);
		settle();
		write_reg(spf_pkg::REG_OUTPUT_CAPACITY, 65535);
	endtask

	task automatic test_block_clamp();
		write_reg(spf_pkg::REG_BLOCK_SIZE, 0);
		send_word(spf_pkg::ACT_START, '0, 8'h00);
		settle();
		write_reg(spf_pkg::REG_BLOCK_SIZE, 63);
		send_word(spf_pkg::ACT_START, '0, 8'h00);
		settle();
		write_reg(spf_pkg::REG_BLOCK_SIZE, 1);
		send_word(spf_pkg::ACT_START, 16'd2, 8'h00);
		send_word(spf_pkg::ACT_DATA, 16'h0000, 8'hC3);
		send_word(spf_pkg::ACT_DATA, 16'h0000, 8'h3C);
		settle();
		write_reg(spf_pkg::REG_BLOCK_SIZE, 8);
	endtask

	// one random sequence: mostly well-formed packets, the rest broken or noise
	task automatic send_sequence(input int unsigned budget);
		int unsigned kind;
		int unsigned len;
		kind = $urandom_range(0, 15);
		if (kind <= 10) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
			if (len >= budget) len = budget - 1;
			send_packet(len);
		end else if (kind == 11) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1000, spf_pkg::MAX_PAYLOAD)
				: $urandom_range(1, 300);
			send_word(spf_pkg::ACT_START, len[spf_pkg::LEN_W-1:0],
				spf_pkg::BYTE_W'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 5))
				send_word(spf_pkg::ACT_DATA, spf_pkg::LEN_W'($urandom_range(0, 65535)),
					spf_pkg::BYTE_W'($urandom_range(0, 255)));
		end else if (kind == 12) begin
			send_word(spf_pkg::ACT_START,
				spf_pkg::LEN_W'($urandom_range(spf_pkg::MAX_PAYLOAD + 1, 65535)),
				spf_pkg::BYTE_W'($urandom_range(0, 255)));
		end else if (kind == 13) begin
			repeat ($urandom_range(1, 3))
				send_word(spf_pkg::ACT_DATA, spf_pkg::LEN_W'($urandom_range(0, 65535)),
					spf_pkg::BYTE_W'($urandom_range(0, 255)));
		end else if (kind == 14) begin
			send_word(1'($urandom_range(0, 1)), spf_pkg::LEN_W'($urandom_range(0, 65535)),
				spf_pkg::BYTE_W'($urandom_range(0, 255)));
		end else begin
			len = $urandom_range(0, 16);
			if (len >= budget) len = budget - 1;
			send_packet(len);
			drain_results();
		end
	endtask

	task automatic test_random_traffic();
		int unsigned target;
		for (int p = 0; p < PHASES; p++) begin
			calm = (p == PHASES - 1);
			write_reg(spf_pkg::REG_BLOCK_SIZE, PHASE_BLK[p]);
			write_reg(spf_pkg::REG_OUTPUT_CAPACITY, PHASE_CAP[p]);
			target = words_in + PHASE_WORDS;
			while (words_in < target) begin
				send_sequence(target - words_in);
				if (p == 2 && words_in >= target - PHASE_WORDS / 2) begin
					drain_results();
					p = p;
				end
			end
			// close any packet still waiting for payload
			if (pk_open)
				send_word(spf_pkg::ACT_START, '0, spf_pkg::BYTE_W'($urandom_range(0, 255)));
			settle();
		end
	endtask

	// output side: random stall bursts, none in the last phase
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_words
		frame_word_t got;
		frame_word_t exp_w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.out_byte = out_ch.out_byte;
			got.is_last  = out_ch.is_last;
			got.status   = out_ch.status;
			words_out++;
			if (frame_q.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected word: expected none, got byte %02h last %0b status %0d",
					$time, got.out_byte, got.is_last, got.status);
			end else begin
				exp_w = frame_q.pop_front();
				if (got.out_byte !== exp_w.out_byte || got.is_last !== exp_w.is_last ||
						got.status !== exp_w.status) begin
					fail_count++;
					$display("%0t: word mismatch: expected byte %02h last %0b status %0d, got byte %02h last %0b status %0d",
						$time, exp_w.out_byte, exp_w.is_last, exp_w.status,
						got.out_byte, got.is_last, got.status);
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no word moved for %0d cycles, %0d words outstanding",
			$time, WATCHDOG_LIMIT, frame_q.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = spf_pkg::REG_BLOCK_SIZE;
		cfg_data             = '0;
		in_ch.valid          = 1'b0;
		in_ch.action         = spf_pkg::ACT_START;
		in_ch.payload_length = '0;
		in_ch.data_byte      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_basic_framing();
		test_length_errors();
		test_capacity();
		test_block_clamp();
		directed_in = words_in;
		test_random_traffic();

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (frame_q.size() != 0) begin
			fail_count++;
			$display("%0t: %0d expected words never arrived", $time, frame_q.size());
		end
		$display("Sent %0d directed and %0d random input words, checked %0d output words",
			directed_in, words_in - directed_in, words_out);
		$display("over %0d register writes incl. clamped block sizes and tight capacities",
			reg_writes);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
design/spf_pkg.sv
design/spf_in_if.sv
design/spf_out_if.sv
design/spf_datapath.sv
design/spf_ctrl.sv
design/ssh_packet_framer.sv
test/ssh_packet_framer_tb.sv
